// File: rtl/rkwd_pkg.sv
// Package: shared types, key constants and key derivation for the rolling-key word decryptor.
package rkwd_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned KeyW  = 32;
  localparam int unsigned NumLanes = 4;
  localparam int unsigned LaneIdxW = $clog2(NumLanes);

  localparam logic [KeyW-1:0] KeyC0 = 32'h5D58_8B65;
  localparam logic [KeyW-1:0] KeyC1 = 32'h359D_3E2A;
  localparam logic [KeyW-1:0] KeyC2 = 32'h70E4_4324;
  localparam logic [KeyW-1:0] KeyC3 = 32'h6C07_8965;

  // Four 16-bit key lanes, lane 0 in the low bits.
  typedef logic [NumLanes-1:0][WordW-1:0] lanes_t;

  typedef struct packed {
    logic [WordW-1:0] plain_word;
    logic             block_end;
  } res_t;

  typedef struct packed {
    logic                keys_loaded;
    logic [LaneIdxW-1:0] lane_index;
  } lane_status_t;

  // Derive both block keys from a seed; returns {k1, k0} as four lanes.
  function automatic lanes_t derive_lanes(input logic [KeyW-1:0] s);
    logic [KeyW-1:0] t;
    logic [KeyW-1:0] u;
    logic [KeyW-1:0] k0;
    logic [KeyW-1:0] k1;
    t  = s ^ (s + KeyC0);
    u  = t ^ (s - KeyC1);
    k0 = u ^ (t - KeyC2);
    k1 = k0 ^ (u + KeyC3);
    return {k1, k0};
  endfunction

endpackage

// File: rtl/rkwd_keygen.sv
// Block key register: derives the four key lanes whenever the seed is written.
module rkwd_keygen import rkwd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            key_seed_we_i,
  input  logic [KeyW-1:0] key_seed_i,
  output lanes_t          key_lanes_o
);

  localparam lanes_t KeyReset = derive_lanes('0);

  lanes_t key_lanes_q;
  lanes_t key_lanes_d;

  assign key_lanes_d = key_seed_we_i ? derive_lanes(key_seed_i) : key_lanes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lanes_q <= KeyReset;
    end else begin
      key_lanes_q <= key_lanes_d;
    end
  end

  assign key_lanes_o = key_lanes_q;

endmodule

// File: rtl/rkwd_lane_unit.sv
// Rolling lane state and the per-word XOR and add.
module rkwd_lane_unit import rkwd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [WordW-1:0] cipher_word_i,
  input  logic             last_word_i,
  input  lanes_t           key_lanes_i,
  output res_t             res_o,
  output lane_status_t     status_o
);

  lanes_t              lanes_q, lanes_d;
  lanes_t              cur_lanes;
  logic [LaneIdxW-1:0] idx_q, idx_d;
  logic [LaneIdxW-1:0] cur_idx;
  logic                loaded_q, loaded_d;
  logic [WordW-1:0]    plain;

  always_comb begin
    // A block start takes fresh lanes and lane zero.
    cur_lanes = loaded_q ? lanes_q : key_lanes_i;
    cur_idx   = loaded_q ? idx_q : '0;
    plain     = cipher_word_i ^ cur_lanes[cur_idx];
    lanes_d   = lanes_q;
    idx_d     = idx_q;
    loaded_d  = loaded_q;
    if (accept_i) begin
      lanes_d          = cur_lanes;
      lanes_d[cur_idx] = cur_lanes[cur_idx] + plain;
      idx_d            = cur_idx + 1'b1;
      loaded_d         = !last_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q  <= '0;
      idx_q    <= '0;
      loaded_q <= 1'b0;
    end else begin
      lanes_q  <= lanes_d;
      idx_q    <= idx_d;
      loaded_q <= loaded_d;
    end
  end

  assign res_o.plain_word      = plain;
  assign res_o.block_end       = last_word_i;
  assign status_o.keys_loaded  = loaded_q;
  assign status_o.lane_index   = idx_q;

endmodule

// File: rtl/rkwd_out_skid.sv
// Result register with a skid stage that absorbs one more item under output stall.
module rkwd_out_skid import rkwd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_data_o
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_data_q, out_data_d;
  res_t skid_data_q, skid_data_d;
  logic out_free;

  always_comb begin
    out_free     = !out_valid_q || !out_stall_i;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      out_valid_d  = skid_valid_q || push_i;
      out_data_d   = skid_valid_q ? skid_data_q : push_data_i;
      skid_valid_d = 1'b0;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/rolling_key_word_decryptor.sv
// Top level: rolling-key word decryptor, seed register, lane unit and output buffer.
//
//   channel   | handshake                    | payload
//   ----------+------------------------------+------------------------------
//   input     | in_valid_i / in_stall_o      | cipher_word_i, last_word_i
//   output    | out_valid_o / out_stall_i    | plain_word_o, block_end_o
//   config    | key_seed_we_i                | key_seed_i
//
// One item per cycle while in_stall_o is low; each result is registered, in the skid stage under stall.
// The lane XOR and add run in the accept cycle, into the result register or the skid stage.
// Key lanes are derived when the seed is written and picked up at the next block start.
// Reset clears the lanes, the lane index and the block state; seed keys reset to those of zero.
// Under output stall a skid stage absorbs one more item, then in_stall_o rises.
module rolling_key_word_decryptor import rkwd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             key_seed_we_i,
  input  logic [KeyW-1:0]  key_seed_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [WordW-1:0] cipher_word_i,
  input  logic             last_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WordW-1:0] plain_word_o,
  output logic             block_end_o
);

  lanes_t       key_lanes;
  res_t         res;
  res_t         out_data;
  lane_status_t status;
  logic         buf_full;
  logic         in_accept;

  // Accept whenever the skid stage has room.
  assign in_stall_o = buf_full;
  assign in_accept  = in_valid_i && !buf_full;

  rkwd_keygen u_keygen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_seed_we_i (key_seed_we_i),
    .key_seed_i    (key_seed_i),
    .key_lanes_o   (key_lanes)
  );

  rkwd_lane_unit u_lane_unit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .cipher_word_i (cipher_word_i),
    .last_word_i   (last_word_i),
    .key_lanes_i   (key_lanes),
    .res_o         (res),
    .status_o      (status)
  );

  rkwd_out_skid u_out_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign plain_word_o = out_data.plain_word;
  assign block_end_o  = out_data.block_end;

  // A full skid stage implies a result is on display.
  assert property (@(posedge clk_i) disable iff (!rst_ni) buf_full |-> out_valid_o)
    else $error("skid stage full without a valid result");

  // Every accepted item leaves a result behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_accept |=> out_valid_o)
    else $error("accepted item produced no result");

  // Block state follows the last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_accept |=> (status.keys_loaded == !$past(last_word_i)))
    else $error("block state does not follow last flag");

  // Lane index advances from the block start or the previous lane.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_accept |=> (status.lane_index ==
        ($past(status.keys_loaded) ? LaneIdxW'($past(status.lane_index) + 1'b1)
                                   : LaneIdxW'(1))))
    else $error("lane index did not advance");

endmodule
